FILE: sv/jtok_pkg.sv
// ----------------------------------------------------------------------------
// jtok_pkg
// Shared types and constants for the JSON tokenizer: token kinds, the result
// bound per byte and the per-byte result bundle.
// ----------------------------------------------------------------------------
package jtok_pkg;

  typedef logic [3:0] kind_t;

  localparam kind_t K_LBRACE   = 4'd0;
  localparam kind_t K_RBRACE   = 4'd1;
  localparam kind_t K_LBRACKET = 4'd2;
  localparam kind_t K_RBRACKET = 4'd3;
  localparam kind_t K_COLON    = 4'd4;
  localparam kind_t K_STRCHAR  = 4'd5;
  localparam kind_t K_STREND   = 4'd6;
  localparam kind_t K_TRUE     = 4'd7;
  localparam kind_t K_NUMCHAR  = 4'd10;
  localparam kind_t K_INT_END  = 4'd11;
  localparam kind_t K_REAL_END = 4'd12;
  localparam kind_t K_DONE     = 4'd13;
  localparam kind_t K_ERROR    = 4'd14;

  localparam int unsigned MAX_RES = 3;

  // Up to three results per byte; a character value only ever rides in slot 0.
  typedef struct packed {
    logic [1:0]              cnt;
    logic [MAX_RES-1:0][3:0] kinds;
    logic [7:0]              chr;
  } jtok_bundle_t;

endpackage

FILE: sv/jtok_front.sv
// ----------------------------------------------------------------------------
// jtok_front
// Lexer front end: takes one byte per transaction, updates the parse state and
// forms the bundle of results caused by that byte.
// ----------------------------------------------------------------------------
module jtok_front import jtok_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         accept,
  input  logic [7:0]   byte_value,
  input  logic         end_of_input,
  output jtok_bundle_t bundle,
  output logic         bundle_valid
);

  typedef enum logic [5:0] {
    M_SEARCH  = 6'b000001,
    M_IDLE    = 6'b000010,
    M_STRING  = 6'b000100,
    M_KEYWORD = 6'b001000,
    M_NUMBER  = 6'b010000,
    M_HALT    = 6'b100000
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [1:0] kw_kind;
    logic       emit;
    kind_t      kind;
  } idle_res_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_EOF   = 8'hFF;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [1:0] KW_TRUE  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_NULL  = 2'd2;

  localparam logic [31:0] TXT_TRUE  = "true";
  localparam logic [39:0] TXT_FALSE = "false";
  localparam logic [31:0] TXT_NULL  = "null";

  function automatic logic [2:0] kw_len(input logic [1:0] kind);
    logic [2:0] l;
    case (kind)
      KW_TRUE:  l = 3'd4;
      KW_FALSE: l = 3'd5;
      KW_NULL:  l = 3'd4;
      default:  l = 3'd0;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] kind, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (kind)
      KW_TRUE: begin
        if (pos < 3'd4) c = TXT_TRUE[8*(3 - pos) +: 8];
      end
      KW_FALSE: begin
        if (pos < 3'd5) c = TXT_FALSE[8*(4 - pos) +: 8];
      end
      KW_NULL: begin
        if (pos < 3'd4) c = TXT_NULL[8*(3 - pos) +: 8];
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

  function automatic idle_res_t lex_idle(input logic [7:0] b, input logic [1:0] kw_in);
    idle_res_t r;
    r.mode    = M_IDLE;
    r.kw_kind = kw_in;
    r.emit    = 1'b0;
    r.kind    = K_ERROR;
    case (b)
      CH_SPACE, CH_COMMA, CH_LF, CH_TAB: begin
        r.emit = 1'b0;
      end
      CH_EOF: begin
        r.emit = 1'b1; r.kind = K_DONE; r.mode = M_HALT;
      end
      CH_LBRC:  begin r.emit = 1'b1; r.kind = K_LBRACE;   end
      CH_RBRC:  begin r.emit = 1'b1; r.kind = K_RBRACE;   end
      CH_LBRK:  begin r.emit = 1'b1; r.kind = K_LBRACKET; end
      CH_RBRK:  begin r.emit = 1'b1; r.kind = K_RBRACKET; end
      CH_COLON: begin r.emit = 1'b1; r.kind = K_COLON;    end
      CH_QUOTE: begin r.mode = M_STRING; end
      CH_T: begin r.mode = M_KEYWORD; r.kw_kind = KW_TRUE;  end
      CH_F: begin r.mode = M_KEYWORD; r.kw_kind = KW_FALSE; end
      CH_N: begin r.mode = M_KEYWORD; r.kw_kind = KW_NULL;  end
      default: begin
        r.emit = 1'b1;
        if (is_digit(b)) begin
          r.kind = K_NUMCHAR; r.mode = M_NUMBER;
        end else begin
          r.kind = K_ERROR; r.mode = M_HALT;
        end
      end
    endcase
    return r;
  endfunction

  mode_t      mode_r, mode_nxt;
  logic [1:0] kw_kind_r, kw_kind_nxt;
  logic [2:0] kw_pos_r, kw_pos_nxt;
  logic       has_chars_r, has_chars_nxt;
  logic       is_real_r, is_real_nxt;

  idle_res_t                ir;
  logic [1:0]               n;
  logic [MAX_RES-1:0][3:0]  k;
  logic [7:0]               chr;
  logic [2:0]               pos_inc;

  always_comb begin
    mode_nxt      = mode_r;
    kw_kind_nxt   = kw_kind_r;
    kw_pos_nxt    = kw_pos_r;
    has_chars_nxt = has_chars_r;
    is_real_nxt   = is_real_r;
    n             = 2'd0;
    k             = {MAX_RES{K_ERROR}};
    chr           = 8'h00;
    ir            = lex_idle(byte_value, kw_kind_r);
    pos_inc       = kw_pos_r + 3'd1;

    if (accept) begin
      case (mode_r)
        M_SEARCH: begin
          if (byte_value == CH_LBRC) begin
            k[n] = K_LBRACE; n = n + 2'd1;
            mode_nxt = M_IDLE;
          end
        end
        M_IDLE: begin
          if (ir.emit) begin
            k[n] = ir.kind; n = n + 2'd1;
          end
          if (ir.kind == K_NUMCHAR) chr = byte_value;
          mode_nxt    = ir.mode;
          kw_kind_nxt = ir.kw_kind;
          if (ir.mode == M_STRING)  has_chars_nxt = 1'b0;
          if (ir.mode == M_KEYWORD) kw_pos_nxt = 3'd1;
          if (ir.mode == M_NUMBER)  is_real_nxt = 1'b0;
        end
        M_STRING: begin
          if (byte_value == CH_QUOTE) begin
            if (has_chars_r) begin
              k[n] = K_STREND; n = n + 2'd1;
              mode_nxt = M_IDLE;
            end else begin
              k[n] = K_ERROR; n = n + 2'd1;
              mode_nxt = M_HALT;
            end
          end else begin
            k[n] = K_STRCHAR; n = n + 2'd1;
            chr = byte_value;
            has_chars_nxt = 1'b1;
          end
        end
        M_KEYWORD: begin
          if (kw_kind_r > KW_NULL || kw_pos_r >= kw_len(kw_kind_r) ||
              byte_value != kw_char(kw_kind_r, kw_pos_r)) begin
            k[n] = K_ERROR; n = n + 2'd1;
            mode_nxt = M_HALT;
          end else begin
            kw_pos_nxt = pos_inc;
            if (pos_inc == kw_len(kw_kind_r)) begin
              k[n] = K_TRUE + {2'b00, kw_kind_r}; n = n + 2'd1;
              mode_nxt = M_IDLE;
            end
          end
        end
        M_NUMBER: begin
          if (is_digit(byte_value)) begin
            k[n] = K_NUMCHAR; n = n + 2'd1;
            chr = byte_value;
          end else if (byte_value == CH_DOT) begin
            if (is_real_r) begin
              k[n] = K_ERROR; n = n + 2'd1;
              mode_nxt = M_HALT;
            end else begin
              k[n] = K_NUMCHAR; n = n + 2'd1;
              chr = byte_value;
              is_real_nxt = 1'b1;
            end
          end else begin
            k[n] = is_real_r ? K_REAL_END : K_INT_END; n = n + 2'd1;
            // terminating byte is lexed as between tokens; never a digit here
            if (ir.emit) begin
              k[n] = ir.kind; n = n + 2'd1;
            end
            mode_nxt    = ir.mode;
            kw_kind_nxt = ir.kw_kind;
            if (ir.mode == M_STRING)  has_chars_nxt = 1'b0;
            if (ir.mode == M_KEYWORD) kw_pos_nxt = 3'd1;
          end
        end
        default: mode_nxt = M_HALT;
      endcase

      if (end_of_input) begin
        if (mode_nxt == M_IDLE) begin
          k[n] = K_DONE; n = n + 2'd1;
        end else if (mode_nxt != M_HALT) begin
          k[n] = K_ERROR; n = n + 2'd1;
        end
        mode_nxt      = M_SEARCH;
        kw_kind_nxt   = KW_TRUE;
        kw_pos_nxt    = 3'd0;
        has_chars_nxt = 1'b0;
        is_real_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_SEARCH;
      kw_kind_r   <= KW_TRUE;
      kw_pos_r    <= 3'd0;
      has_chars_r <= 1'b0;
      is_real_r   <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      kw_kind_r   <= kw_kind_nxt;
      kw_pos_r    <= kw_pos_nxt;
      has_chars_r <= has_chars_nxt;
      is_real_r   <= is_real_nxt;
    end
  end

  assign bundle.cnt   = n;
  assign bundle.kinds = k;
  assign bundle.chr   = chr;
  assign bundle_valid = accept && (n != 2'd0);

endmodule

FILE: sv/jtok_queue.sv
// ----------------------------------------------------------------------------
// jtok_queue
// Small bundle FIFO between the lexer front end and the result serializer.
// ----------------------------------------------------------------------------
module jtok_queue import jtok_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  jtok_bundle_t wdata,
  input  logic         pop,
  output jtok_bundle_t rdata,
  output logic         full,
  output logic         empty
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  jtok_bundle_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  assign rdata = mem_r[rd_ptr_r];
  assign full  = (cnt_r == FULL_CNT);
  assign empty = (cnt_r == '0);

endmodule

FILE: sv/jtok_back.sv
// ----------------------------------------------------------------------------
// jtok_back
// Result serializer: walks the head bundle one result per transaction and
// releases it from the queue after its last result.
// ----------------------------------------------------------------------------
module jtok_back import jtok_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  jtok_bundle_t head,
  input  logic         head_empty,
  input  logic         pop,
  output logic         head_pop,
  output logic [3:0]   token_kind,
  output logic [7:0]   char_value,
  output logic         last_of_run
);

  logic [1:0] idx_r, idx_nxt;
  logic       fire;

  assign fire        = pop && !head_empty;
  assign last_of_run = (idx_r == head.cnt - 2'd1);
  assign head_pop    = fire && last_of_run;
  assign token_kind  = head.kinds[idx_r];
  assign char_value  = (idx_r == 2'd0) ? head.chr : 8'h00;

  always_comb begin
    idx_nxt = idx_r;
    if (fire) idx_nxt = last_of_run ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

FILE: sv/json_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// json_tokenizer_unit
// Byte-serial JSON lexer producing token events through queue-style ports.
// ----------------------------------------------------------------------------
// A byte is taken in every cycle in which in_push is high and the internal
// result queue has room (QDEPTH bundles); the lexer handles it in that same
// cycle. A byte gives zero to three results, and the serializer on the result
// side hands out one result per cycle while out_pop is high, so the sustained
// rate is one byte per cycle while bytes give at most one result each, and
// less for bytes giving more. A byte's results are queued before the ports.
module json_tokenizer_unit import jtok_pkg::*; #(
  parameter int unsigned QDEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_byte_value,
  input  logic       in_end_of_input,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [3:0] out_token_kind,
  output logic [7:0] out_char_value,
  output logic       out_last_of_run
);

  jtok_bundle_t fe_bundle, q_head;
  logic         fe_valid;
  logic         in_accept;
  logic         q_empty, q_full, q_pop;

  assign in_accept = in_push && !in_full;
  assign in_full   = q_full;
  assign out_empty = q_empty;

  jtok_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .byte_value   (in_byte_value),
    .end_of_input (in_end_of_input),
    .bundle       (fe_bundle),
    .bundle_valid (fe_valid)
  );

  jtok_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fe_valid),
    .wdata (fe_bundle),
    .pop   (q_pop),
    .rdata (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  jtok_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (q_head),
    .head_empty  (q_empty),
    .pop         (out_pop),
    .head_pop    (q_pop),
    .token_kind  (out_token_kind),
    .char_value  (out_char_value),
    .last_of_run (out_last_of_run)
  );

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    fe_valid |=> !out_empty)
    else $error("queued results not visible");

  a_char_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_token_kind != K_STRCHAR && out_token_kind != K_NUMCHAR)
      |-> (out_char_value == 8'h00))
    else $error("char value on non-character token");

  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_token_kind == K_DONE || out_token_kind == K_ERROR))
      |-> out_last_of_run)
    else $error("terminal token not last of run");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_token_kind <= K_ERROR))
    else $error("token kind out of range");

endmodule
